@@ src/point_occupancy_grid_binning_top_macros.svh @@
// Assertion macros for the occupancy grid binning block.
// Used by the top level only; no other dependencies.
`ifndef POINT_OCCUPANCY_GRID_BINNING_TOP_MACROS_SVH
`define POINT_OCCUPANCY_GRID_BINNING_TOP_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define POGB_ASSERT_SAME(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define POGB_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ src/pogb_pkg.sv @@
// Shared types and constants for the occupancy grid binning block.
// No dependencies; imported by every module of the block.
package pogb_pkg;

    localparam int COORD_BITS    = 16;
    localparam int CS_BITS       = 15;
    localparam int DIV_BITS      = 16;
    localparam int CELL_BITS     = 14;
    localparam int OCC_BITS      = 7;
    localparam int COUNT_BITS    = 7;
    // Address field wide enough for the largest supported grid (2^20 cells)
    localparam int CMD_ADDR_BITS = 20;
    localparam int CFG_IDX_BITS  = 4;
    localparam int CFG_DATA_BITS = 16;
    localparam int QUEUE_DEPTH   = 4;
    localparam int QPTR_BITS     = $clog2(QUEUE_DEPTH);

    localparam logic [COUNT_BITS-1:0] COUNT_MAX = 7'd127;
    localparam logic [OCC_BITS-1:0]   OCC_VALUE = 7'd100;

    typedef enum logic [1:0] {
        MODE_ADD   = 2'd0,
        MODE_READ  = 2'd1,
        MODE_CLEAR = 2'd2,
        MODE_NONE  = 2'd3
    } t_mode;

    typedef enum logic [CFG_IDX_BITS-1:0] {
        CFG_MAP_MIN_X      = 4'd0,
        CFG_MAP_MAX_X      = 4'd1,
        CFG_MAP_MIN_Y      = 4'd2,
        CFG_MAP_MAX_Y      = 4'd3,
        CFG_CELL_SIZE      = 4'd4,
        CFG_VEHICLE_WIDTH  = 4'd5,
        CFG_VEHICLE_LENGTH = 4'd6,
        CFG_HIT_THRESHOLD  = 4'd7
    } t_cfg_idx;

    typedef struct packed {
        logic [1:0]            mode;
        logic [COORD_BITS-1:0] point_forward;
        logic [COORD_BITS-1:0] point_left;
        logic [CELL_BITS-1:0]  read_index;
    } t_in_item;

    typedef struct packed {
        logic                 point_taken;
        logic [CELL_BITS-1:0] cell_number;
        logic [OCC_BITS-1:0]  occupancy;
    } t_out_item;

    typedef struct packed {
        logic [COORD_BITS-1:0] map_min_x;
        logic [COORD_BITS-1:0] map_max_x;
        logic [COORD_BITS-1:0] map_min_y;
        logic [COORD_BITS-1:0] map_max_y;
        logic [CS_BITS-1:0]    cell_size;
        logic [CS_BITS-1:0]    vehicle_width;
        logic [CS_BITS-1:0]    vehicle_length;
        logic [COUNT_BITS-1:0] hit_threshold;
    } t_cfg;

    localparam t_cfg CFG_RESET = '{
        map_min_x:      -16'sd2000,
        map_max_x:      16'sd2000,
        map_min_y:      -16'sd2000,
        map_max_y:      16'sd2000,
        cell_size:      15'd40,
        vehicle_width:  15'd200,
        vehicle_length: 15'd450,
        hit_threshold:  7'd2
    };

    // Classified work handed from the front end to the grid back end
    typedef struct packed {
        t_mode                    op;
        logic                     hit;
        logic [CELL_BITS-1:0]     cell_idx;
        logic [CMD_ADDR_BITS-1:0] addr;
    } t_cmd;

endpackage

@@ src/pogb_div.sv @@
// Restoring divider, one quotient bit per cycle, for the binning front end.
// Depends on pogb_pkg for operand widths.
module pogb_div import pogb_pkg::*; (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_start,
    input  logic [DIV_BITS-1:0] i_dividend,
    input  logic [CS_BITS-1:0]  i_divisor,
    output logic                o_done,
    output logic [DIV_BITS-1:0] o_quotient
);

    localparam int CNT_BITS = $clog2(DIV_BITS);

    logic                r_busy;
    logic                r_done;
    logic [CNT_BITS-1:0] r_cnt;
    logic [DIV_BITS-1:0] r_rem;
    logic [DIV_BITS-1:0] r_quo;
    logic [CS_BITS-1:0]  r_dvs;

    logic [DIV_BITS-1:0] w_trial;
    logic                w_ge;
    logic [DIV_BITS-1:0] n_rem;

    // Dividend bits shift out of the top of r_quo while quotient bits shift in
    assign w_trial = {r_rem[DIV_BITS-2:0], r_quo[DIV_BITS-1]};
    assign w_ge    = (w_trial >= DIV_BITS'(r_dvs));
    assign n_rem   = w_ge ? (w_trial - DIV_BITS'(r_dvs)) : w_trial;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + CNT_BITS'(1);
                if (r_cnt == CNT_BITS'(DIV_BITS - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem <= '0;
            r_quo <= i_dividend;
            r_dvs <= i_divisor;
        end else if (r_busy) begin
            r_rem <= n_rem;
            r_quo <= {r_quo[DIV_BITS-2:0], w_ge};
        end
    end

    assign o_done     = r_done;
    assign o_quotient = r_quo;

endmodule

@@ src/pogb_front.sv @@
// Front end: accepts items, transforms and bounds-checks points, finds cell
// indices with one divider per lane. Depends on pogb_pkg and pogb_div.
module pogb_front import pogb_pkg::*; #(
    parameter int GRID_CELLS = 16384
) (
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_in_valid,
    output logic     o_in_stall,
    input  t_in_item i_in_data,
    input  t_cfg     i_cfg,
    input  logic     i_hold,
    input  logic     i_full,
    output logic     o_push,
    output t_cmd     o_cmd
);

    localparam int PROD_BITS = 2 * DIV_BITS;
    localparam int SUM_BITS  = PROD_BITS + 1;
    localparam logic [SUM_BITS-1:0] GRID_LIM = SUM_BITS'(GRID_CELLS);

    localparam int LANE_XC = 0;
    localparam int LANE_YC = 1;
    localparam int LANE_XN = 2;
    localparam int LANE_YN = 3;
    localparam int LANES   = 4;

    typedef enum logic [2:0] {
        F_IDLE,
        F_PREP,
        F_DIV,
        F_MUL,
        F_PUSH
    } t_fstate;

    t_fstate r_state;

    logic [1:0]                  r_mode;
    logic signed [COORD_BITS:0]  r_x;
    logic signed [COORD_BITS:0]  r_y;
    logic [CELL_BITS-1:0]        r_ri;
    logic                        r_keep;
    logic                        r_fits;
    logic [PROD_BITS-1:0]        r_prod;

    logic                        w_accept;
    logic signed [COORD_BITS:0]  w_min_x, w_max_x, w_min_y, w_max_y;
    logic signed [COORD_BITS+1:0] w_dx, w_dy;
    logic signed [COORD_BITS:0]  w_span_x, w_span_y;
    logic [COORD_BITS:0]         w_ax, w_ay;
    logic                        w_inb;
    logic                        w_veh;
    logic [CS_BITS-1:0]          w_cs;
    logic [DIV_BITS-1:0]         w_num [LANES];
    logic [DIV_BITS-1:0]         w_quo [LANES];
    logic [LANES-1:0]            w_done;
    logic [DIV_BITS-1:0]         w_mul_a;
    logic [PROD_BITS-1:0]        w_prod;
    logic [SUM_BITS-1:0]         w_sum;
    t_cmd                        w_cmd;

    assign o_in_stall = (r_state != F_IDLE) || i_hold;
    assign w_accept   = i_in_valid && !o_in_stall;

    assign w_min_x = $signed({i_cfg.map_min_x[COORD_BITS-1], i_cfg.map_min_x});
    assign w_max_x = $signed({i_cfg.map_max_x[COORD_BITS-1], i_cfg.map_max_x});
    assign w_min_y = $signed({i_cfg.map_min_y[COORD_BITS-1], i_cfg.map_min_y});
    assign w_max_y = $signed({i_cfg.map_max_y[COORD_BITS-1], i_cfg.map_max_y});

    assign w_dx     = $signed({r_x[COORD_BITS], r_x}) - $signed({w_min_x[COORD_BITS], w_min_x});
    assign w_dy     = $signed({r_y[COORD_BITS], r_y}) - $signed({w_min_y[COORD_BITS], w_min_y});
    assign w_span_x = w_max_x - w_min_x;
    assign w_span_y = w_max_y - w_min_y;

    assign w_ax = r_x[COORD_BITS] ? $unsigned(-r_x) : $unsigned(r_x);
    assign w_ay = r_y[COORD_BITS] ? $unsigned(-r_y) : $unsigned(r_y);

    assign w_inb = (r_x >= w_min_x) && (r_x <= w_max_x)
                && (r_y >= w_min_y) && (r_y <= w_max_y);
    assign w_veh = ({w_ax, 1'b0} <= (COORD_BITS + 2)'(i_cfg.vehicle_width))
                && ({w_ay, 1'b0} <= (COORD_BITS + 2)'(i_cfg.vehicle_length));

    assign w_cs = (i_cfg.cell_size == '0) ? CS_BITS'(1) : i_cfg.cell_size;

    // Offsets only matter when the point is in bounds, where they fit 16 bits
    assign w_num[LANE_XC] = w_dx[DIV_BITS-1:0];
    assign w_num[LANE_YC] = w_dy[DIV_BITS-1:0];
    assign w_num[LANE_XN] = w_span_x[COORD_BITS] ? '0 : w_span_x[DIV_BITS-1:0];
    assign w_num[LANE_YN] = w_span_y[COORD_BITS] ? '0 : w_span_y[DIV_BITS-1:0];

    for (genvar g = 0; g < LANES; g++) begin : g_lane
        pogb_div u_div (
            .i_clk      (i_clk),
            .i_rst_n    (i_rst_n),
            .i_start    (r_state == F_PREP),
            .i_dividend (w_num[g]),
            .i_divisor  (w_cs),
            .o_done     (w_done[g]),
            .o_quotient (w_quo[g])
        );
    end

    assign w_mul_a = (r_mode == MODE_ADD) ? w_quo[LANE_YC] : w_quo[LANE_YN];
    assign w_prod  = PROD_BITS'(w_mul_a) * PROD_BITS'(w_quo[LANE_XN]);
    assign w_sum   = SUM_BITS'(r_prod) + SUM_BITS'(w_quo[LANE_XC]);

    always_comb begin
        w_cmd = '{op: MODE_NONE, hit: 1'b0, cell_idx: '0, addr: '0};
        case (r_mode)
            MODE_ADD: begin
                w_cmd.op       = MODE_ADD;
                w_cmd.hit      = r_keep && r_fits && (w_sum < GRID_LIM);
                w_cmd.cell_idx = w_cmd.hit ? w_sum[CELL_BITS-1:0] : '0;
                w_cmd.addr     = w_sum[CMD_ADDR_BITS-1:0];
            end
            MODE_READ: begin
                w_cmd.op       = MODE_READ;
                w_cmd.hit      = (PROD_BITS'(r_ri) < r_prod) && (SUM_BITS'(r_ri) < GRID_LIM);
                w_cmd.cell_idx = r_ri;
                w_cmd.addr     = CMD_ADDR_BITS'(r_ri);
            end
            MODE_CLEAR: begin
                w_cmd.op = MODE_CLEAR;
            end
            default: begin
                w_cmd.op = MODE_NONE;
            end
        endcase
    end

    assign o_push = (r_state == F_PUSH) && !i_full;
    assign o_cmd  = w_cmd;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= F_IDLE;
        end else begin
            case (r_state)
                F_IDLE: begin
                    if (w_accept) begin
                        if ((i_in_data.mode == MODE_ADD) || (i_in_data.mode == MODE_READ)) begin
                            r_state <= F_PREP;
                        end else begin
                            r_state <= F_PUSH;
                        end
                    end
                end
                F_PREP: begin
                    r_state <= F_DIV;
                end
                F_DIV: begin
                    if (&w_done) begin
                        r_state <= F_MUL;
                    end
                end
                F_MUL: begin
                    r_state <= F_PUSH;
                end
                F_PUSH: begin
                    if (!i_full) begin
                        r_state <= F_IDLE;
                    end
                end
                default: begin
                    r_state <= F_IDLE;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_mode <= i_in_data.mode;
            // local x is minus sensor left, local y is sensor forward
            r_x    <= -$signed({i_in_data.point_left[COORD_BITS-1], i_in_data.point_left});
            r_y    <= $signed({i_in_data.point_forward[COORD_BITS-1], i_in_data.point_forward});
            r_ri   <= i_in_data.read_index;
        end
        if (r_state == F_PREP) begin
            r_keep <= w_inb && !w_veh;
        end
        if (r_state == F_MUL) begin
            r_prod <= w_prod;
            r_fits <= (w_quo[LANE_XC] < w_quo[LANE_XN]) && (w_quo[LANE_YC] < w_quo[LANE_YN]);
        end
    end

endmodule

@@ src/pogb_queue.sv @@
// Short command queue between the binning front end and the grid back end.
// Depends on pogb_pkg for the command word and depth.
module pogb_queue import pogb_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_push,
    input  t_cmd i_cmd,
    input  logic i_pop,
    output logic o_full,
    output logic o_empty,
    output t_cmd o_head
);

    t_cmd                 r_slots [QUEUE_DEPTH];
    logic [QPTR_BITS-1:0] r_wr;
    logic [QPTR_BITS-1:0] r_rd;
    logic [QPTR_BITS:0]   r_count;

    assign o_full  = (r_count == (QPTR_BITS + 1)'(QUEUE_DEPTH));
    assign o_empty = (r_count == '0);
    assign o_head  = r_slots[r_rd];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            if (i_push) begin
                r_wr <= r_wr + QPTR_BITS'(1);
            end
            if (i_pop) begin
                r_rd <= r_rd + QPTR_BITS'(1);
            end
            if (i_push && !i_pop) begin
                r_count <= r_count + (QPTR_BITS + 1)'(1);
            end else if (i_pop && !i_push) begin
                r_count <= r_count - (QPTR_BITS + 1)'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_slots[r_wr] <= i_cmd;
        end
    end

endmodule

@@ src/pogb_back.sv @@
// Back end: holds the per-cell hit counters in a memory, applies add, read
// and clear commands, and drives the result register. Depends on pogb_pkg.
module pogb_back import pogb_pkg::*; #(
    parameter int GRID_CELLS = 16384
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_empty,
    input  t_cmd                  i_head,
    output logic                  o_pop,
    input  logic [COUNT_BITS-1:0] i_threshold,
    output logic                  o_sweeping,
    output logic                  o_out_valid,
    input  logic                  i_out_stall,
    output t_out_item             o_out_data
);

    localparam int AW = $clog2(GRID_CELLS);
    localparam logic [AW-1:0] LAST_CELL = AW'(GRID_CELLS - 1);

    typedef enum logic [1:0] {
        B_SWEEP,
        B_IDLE,
        B_DONE
    } t_bstate;

    t_bstate r_state;

    logic [COUNT_BITS-1:0] r_counts [GRID_CELLS];
    logic [COUNT_BITS-1:0] r_rdata;
    logic [AW-1:0]         r_pos;
    logic                  r_frame;
    t_cmd                  r_cmd;
    logic                  r_out_valid;
    t_out_item             r_out;

    logic                  w_out_free;
    logic                  w_finish;
    logic                  w_we;
    logic [AW-1:0]         w_waddr;
    logic [COUNT_BITS-1:0] w_wdata;
    logic [COUNT_BITS-1:0] w_inc;
    t_out_item             w_res;

    assign o_pop      = (r_state == B_IDLE) && !i_empty;
    assign w_out_free = !r_out_valid || !i_out_stall;
    assign w_finish   = (r_state == B_DONE) && w_out_free;

    // Saturate the hit counter
    assign w_inc   = (r_rdata < COUNT_MAX) ? (r_rdata + COUNT_BITS'(1)) : r_rdata;
    assign w_we    = (r_state == B_SWEEP)
                  || (w_finish && (r_cmd.op == MODE_ADD) && r_cmd.hit);
    assign w_waddr = (r_state == B_SWEEP) ? r_pos : r_cmd.addr[AW-1:0];
    assign w_wdata = (r_state == B_SWEEP) ? '0 : w_inc;

    always_comb begin
        w_res = '{point_taken: 1'b0, cell_number: '0, occupancy: '0};
        case (r_cmd.op)
            MODE_ADD: begin
                w_res.point_taken = r_cmd.hit;
                w_res.cell_number = r_cmd.cell_idx;
            end
            MODE_READ: begin
                w_res.cell_number = r_cmd.cell_idx;
                if (r_cmd.hit && r_frame && (r_rdata >= i_threshold)) begin
                    w_res.occupancy = OCC_VALUE;
                end
            end
            default: begin
                w_res = '{point_taken: 1'b0, cell_number: '0, occupancy: '0};
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (w_we) begin
            r_counts[w_waddr] <= w_wdata;
        end
        if (o_pop) begin
            r_rdata <= r_counts[i_head.addr[AW-1:0]];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= B_SWEEP;
            r_pos       <= '0;
            r_frame     <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (w_finish) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                B_SWEEP: begin
                    r_pos <= r_pos + AW'(1);
                    if (r_pos == LAST_CELL) begin
                        r_state <= B_IDLE;
                    end
                end
                B_IDLE: begin
                    if (o_pop) begin
                        r_state <= B_DONE;
                    end
                end
                B_DONE: begin
                    if (w_finish) begin
                        if (r_cmd.op == MODE_CLEAR) begin
                            r_frame <= 1'b0;
                            r_pos   <= '0;
                            r_state <= B_SWEEP;
                        end else begin
                            // any added point marks the frame, dropped or not
                            if (r_cmd.op == MODE_ADD) begin
                                r_frame <= 1'b1;
                            end
                            r_state <= B_IDLE;
                        end
                    end
                end
                default: begin
                    r_state <= B_IDLE;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_cmd <= i_head;
        end
        if (w_finish) begin
            r_out <= w_res;
        end
    end

    assign o_sweeping  = (r_state == B_SWEEP);
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

endmodule

@@ src/point_occupancy_grid_binning_top.sv @@
// Occupancy grid binning, top level: configuration registers, front end,
// command queue and counter back end. Depends on pogb_pkg and the macros header.
//
// Input words carry a mode: add a lidar point, read one cell, or clear the
// grid. Every input word yields exactly one output word, in order. Points are
// rotated into local axes, dropped when outside the map or inside the vehicle
// box, and otherwise counted into their cell (counters saturate at 127).
// The front end takes a new word only after it has pushed the last one
// into the queue; 16-step restoring dividers turn offsets and spans into
// cell numbers. A clear returns its word, then sweeps the counter memory
// one cell per cycle with the input stalled. After reset the same sweep
// runs before any word is taken. A stalled output holds its word; the
// front end keeps working into the queue until it fills. Configuration
// writes are taken in any cycle.
`include "point_occupancy_grid_binning_top_macros.svh"

module point_occupancy_grid_binning_top import pogb_pkg::*; #(
    parameter int GRID_CELLS = 16384
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_in_valid,
    output logic                     o_in_stall,
    input  t_in_item                 i_in_data,
    output logic                     o_out_valid,
    input  logic                     i_out_stall,
    output t_out_item                o_out_data,
    input  logic                     i_cfg_valid,
    output logic                     o_cfg_ready,
    input  logic [CFG_IDX_BITS-1:0]  i_cfg_index,
    input  logic [CFG_DATA_BITS-1:0] i_cfg_data
);

    t_cfg r_cfg;

    logic w_sweeping;
    logic w_push;
    logic w_pop;
    logic w_full;
    logic w_empty;
    t_cmd w_cmd;
    t_cmd w_head;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= CFG_RESET;
        end else if (i_cfg_valid && o_cfg_ready) begin
            case (i_cfg_index)
                CFG_MAP_MIN_X:      r_cfg.map_min_x      <= i_cfg_data;
                CFG_MAP_MAX_X:      r_cfg.map_max_x      <= i_cfg_data;
                CFG_MAP_MIN_Y:      r_cfg.map_min_y      <= i_cfg_data;
                CFG_MAP_MAX_Y:      r_cfg.map_max_y      <= i_cfg_data;
                CFG_CELL_SIZE:      r_cfg.cell_size      <= i_cfg_data[CS_BITS-1:0];
                CFG_VEHICLE_WIDTH:  r_cfg.vehicle_width  <= i_cfg_data[CS_BITS-1:0];
                CFG_VEHICLE_LENGTH: r_cfg.vehicle_length <= i_cfg_data[CS_BITS-1:0];
                CFG_HIT_THRESHOLD:  r_cfg.hit_threshold  <= i_cfg_data[COUNT_BITS-1:0];
                default:            r_cfg                <= r_cfg;
            endcase
        end
    end

    pogb_front #(
        .GRID_CELLS (GRID_CELLS)
    ) u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_in_data  (i_in_data),
        .i_cfg      (r_cfg),
        .i_hold     (w_sweeping),
        .i_full     (w_full),
        .o_push     (w_push),
        .o_cmd      (w_cmd)
    );

    pogb_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_cmd   (w_cmd),
        .i_pop   (w_pop),
        .o_full  (w_full),
        .o_empty (w_empty),
        .o_head  (w_head)
    );

    pogb_back #(
        .GRID_CELLS (GRID_CELLS)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_empty     (w_empty),
        .i_head      (w_head),
        .o_pop       (w_pop),
        .i_threshold (r_cfg.hit_threshold),
        .o_sweeping  (w_sweeping),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_data  (o_out_data)
    );

    `POGB_ASSERT_SAME(a_no_accept_in_sweep, i_clk, i_rst_n, w_sweeping, o_in_stall, "word accepted during sweep")
    `POGB_ASSERT_SAME(a_no_push_when_full, i_clk, i_rst_n, w_push, !w_full, "push into full queue")
    `POGB_ASSERT_SAME(a_occupancy_code, i_clk, i_rst_n, o_out_valid && (o_out_data.occupancy != '0), (o_out_data.occupancy == OCC_VALUE) && !o_out_data.point_taken, "bad occupancy result")
    `POGB_ASSERT_NEXT(a_one_pop_per_word, i_clk, i_rst_n, w_pop, !w_pop, "back end popped twice in a row")

endmodule
